// File: hdl/t2c_pkg.sv
// Shared types, marker codes and letter tables for the transliteration decoder.
// No dependencies.
`timescale 1ns / 1ps

package t2c_pkg;

    localparam logic [7:0] MARK_PAIR   = 8'h12;
    localparam logic [7:0] MARK_TRIPLE = 8'h13;
    localparam logic [7:0] MARK_LATIN  = 8'h14;
    localparam logic [7:0] MARK_CYRIL  = 8'h15;

    localparam logic [7:0] CH_BACKTICK = 8'h60;
    localparam logic [7:0] CH_QUERY    = 8'h3f;
    localparam logic [7:0] CYR_HARD    = 8'hfa;
    localparam logic [7:0] CYR_SHCH    = 8'hf9;
    localparam logic [7:0] CYR_SOFT    = 8'hfc;
    localparam logic [7:0] CYR_YO      = 8'hb8;
    localparam logic [7:0] CYR_YO_UP   = 8'ha8;
    localparam logic [7:0] CYR_YA      = 8'hff;
    localparam logic [7:0] CYR_YU      = 8'hfe;
    localparam logic [7:0] CYR_YERU    = 8'hfb;
    localparam logic [7:0] CASE_MASK   = 8'hdf;

    localparam logic [1:0] PEND_PAIR   = 2'd2;
    localparam logic [1:0] PEND_TRIPLE = 2'd3;

    typedef struct packed {
        logic       latin_mode;
        logic [1:0] bytes_pending;
        logic       triple_seq;
        logic [7:0] first_seq_byte;
        logic [7:0] previous_letter;
    } dec_state_t;

    function automatic logic is_up(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5a);
    endfunction

    function automatic logic is_low(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7a);
    endfunction

    function automatic logic [7:0] to_low(input logic [7:0] c);
        return is_up(c) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [7:0] cyr_upper(input logic [7:0] c);
        return (c == CYR_YO) ? CYR_YO_UP : (c & CASE_MASK);
    endfunction

    // a..z, indexed from zero
    function automatic logic [7:0] letter_map(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0:    r = 8'he0;
            5'd1:    r = 8'he1;
            5'd2:    r = 8'hf6;
            5'd3:    r = 8'he4;
            5'd4:    r = 8'he5;
            5'd5:    r = 8'hf4;
            5'd6:    r = 8'he3;
            5'd7:    r = 8'hf5;
            5'd8:    r = 8'he8;
            5'd9:    r = 8'he9;
            5'd10:   r = 8'hea;
            5'd11:   r = 8'heb;
            5'd12:   r = 8'hec;
            5'd13:   r = 8'hed;
            5'd14:   r = 8'hee;
            5'd15:   r = 8'hef;
            5'd16:   r = CH_QUERY;
            5'd17:   r = 8'hf0;
            5'd18:   r = 8'hf1;
            5'd19:   r = 8'hf2;
            5'd20:   r = 8'hf3;
            5'd21:   r = 8'he2;
            5'd22:   r = CH_QUERY;
            5'd23:   r = 8'hf5;
            5'd24:   r = 8'hfb;
            5'd25:   r = 8'he7;
            default: r = CH_QUERY;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/t2c_decode.sv
// Combinational decode of one byte against the current decoder state.
// Depends on t2c_pkg.
`timescale 1ns / 1ps

module t2c_decode
    import t2c_pkg::*;
(
    input  logic [7:0] in_byte,
    input  dec_state_t state,
    output dec_state_t state_next,
    output logic       emit,
    output logic [7:0] result
);

    logic [7:0] first;
    logic [7:0] pair_r;
    logic [7:0] single_r;
    logic [7:0] map_r;
    logic [1:0] total;

    assign total = state.triple_seq ? PEND_TRIPLE : PEND_PAIR;
    assign first = state.first_seq_byte;
    assign map_r = letter_map(in_byte[4:0] - 5'd1);

    always_comb
    begin
        pair_r = CH_QUERY;
        if (first == CH_BACKTICK)
        begin
            pair_r = is_up(state.previous_letter) ? cyr_upper(CYR_HARD) : CYR_HARD;
        end
        else
        begin
            case (to_low(first))
                8'h7a:   pair_r = 8'he6;
                8'h63:   pair_r = 8'hf7;
                8'h73:   pair_r = 8'hf8;
                8'h65:   pair_r = 8'hfd;
                8'h79:
                begin
                    if (in_byte == 8'h61)
                        pair_r = CYR_YA;
                    else if (in_byte == CH_BACKTICK)
                        pair_r = CYR_YERU;
                    else if (in_byte == 8'h6f)
                        pair_r = CYR_YO;
                    else
                        pair_r = CYR_YU;
                end
                default: pair_r = CH_QUERY;
            endcase
            if (pair_r != CH_QUERY && is_up(first))
                pair_r = cyr_upper(pair_r);
        end
    end

    always_comb
    begin
        if (is_up(in_byte) || is_low(in_byte))
            single_r = (map_r == CH_QUERY || !is_up(in_byte)) ? map_r : cyr_upper(map_r);
        else if (in_byte == CH_BACKTICK)
            single_r = is_up(state.previous_letter) ? cyr_upper(CYR_SOFT) : CYR_SOFT;
        else
            single_r = in_byte;
    end

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        result     = in_byte;
        if (state.bytes_pending != 2'd0)
        begin
            if (state.bytes_pending == total)
                state_next.first_seq_byte = in_byte;
            state_next.bytes_pending = state.bytes_pending - 2'd1;
            if (state.bytes_pending == 2'd1)
            begin
                emit = 1'b1;
                if (state.triple_seq)
                    result = is_up(first) ? cyr_upper(CYR_SHCH) : CYR_SHCH;
                else
                    result = pair_r;
                state_next.previous_letter = first;
            end
        end
        else if (state.latin_mode)
        begin
            if (in_byte == MARK_CYRIL)
                state_next.latin_mode = 1'b0;
            else
                emit = 1'b1;
        end
        else
        begin
            case (in_byte)
                MARK_PAIR:
                begin
                    state_next.triple_seq    = 1'b0;
                    state_next.bytes_pending = PEND_PAIR;
                end
                MARK_TRIPLE:
                begin
                    state_next.triple_seq    = 1'b1;
                    state_next.bytes_pending = PEND_TRIPLE;
                end
                MARK_LATIN: state_next.latin_mode = 1'b1;
                MARK_CYRIL: state_next.latin_mode = 1'b0;
                default:
                begin
                    emit                       = 1'b1;
                    result                     = single_r;
                    state_next.previous_letter = in_byte;
                end
            endcase
        end
    end

endmodule

// File: hdl/translit_to_cp1251_decoder.sv
// Path: input register, then result register, from input beat to output beat.
// Throughput: one beat per cycle while in_stall is low; marker and sequence bytes that give no output
// retire even while the output is stalled.
// Reset: rst_n asynchronous, active low; Cyrillic mode, no open sequence, both
// registers empty.
`timescale 1ns / 1ps

module translit_to_cp1251_decoder
    import t2c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    dec_state_t st_reg;
    dec_state_t st_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       emit;
    logic [7:0] result;
    logic       out_free;
    logic       s1_fire;

    t2c_decode u_decode (
        .in_byte    (s1_byte_reg),
        .state      (st_reg),
        .state_next (st_next),
        .emit       (emit),
        .result     (result)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && (!emit || out_free);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (s1_fire)
                st_reg <= st_next;
            if (s1_fire && emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_byte_reg <= in_byte;
        if (s1_fire && emit)
            out_byte_reg <= result;
    end

`ifndef SYNTHESIS
    a_latin_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.latin_mode |-> st_reg.bytes_pending == 2'd0)
        else $error("sequence open in latin mode");
    a_triple_pending: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.bytes_pending == PEND_TRIPLE |-> st_reg.triple_seq)
        else $error("three pending without triple sequence");
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && emit |=> out_valid_reg && out_byte_reg == $past(result))
        else $error("decoded beat lost");
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && emit && out_valid_reg && out_stall)
        else $error("input stalled without cause");
`endif

endmodule
